[sv/sincos_pkg.sv]
// ----------------------------------------------------------------------------
// Sine and cosine package
// Shared types, pipeline depth and polynomial coefficients for the
// fixed-point sine and cosine evaluator.
// ----------------------------------------------------------------------------
package sincos_pkg;

  // Horner accumulator, signed Q2.30.
  typedef logic signed [31:0] acc_t;

  // Reduced angle and its square, travelling alongside the accumulators.
  typedef struct packed {
    logic [31:0] y2;       // y*y, unsigned Q2.30
    logic        y30_neg;  // sign of the reduced angle
    logic [30:0] y30_mag;  // magnitude of the reduced angle, Q1.30
    logic        flip;     // cosine sign must be negated
  } arg_t;

  // Stage counts of the three pipeline sections.
  localparam int REDUCE_STAGES = 8;
  localparam int HORNER_STEPS  = 5;
  localparam int FINISH_STAGES = 3;
  localparam int SINCOS_LATENCY = REDUCE_STAGES + 2 * HORNER_STEPS + FINISH_STAGES;

  // Starting accumulators (highest-order coefficients, negated).
  localparam acc_t SIN_INIT = -32'sd26;
  localparam acc_t COS_INIT = -32'sd280;

  // Constant added after each Horner multiplication, Q.30.
  localparam acc_t SIN_ADD [HORNER_STEPS] = '{
    32'sd2956, -32'sd213040, 32'sd8947846, -32'sd178956974, 32'sd1073741824
  };
  localparam acc_t COS_ADD [HORNER_STEPS] = '{
    32'sd26586, -32'sd1491253, 32'sd44739212, -32'sd536870912, 32'sd1073741824
  };

endpackage

[sv/sine_cosine_polynomial.sv]
// Throughput: one angle per cycle while nothing stalls the pipeline; every
// stage is a multiply or an add-and-round step, so the 32x32 Horner
// multipliers set the clock period.
// A stalled output back-pressures stage by stage; empty stages keep loading.
// Reset clears the valid bits of all stages; the data registers are not reset.
// ----------------------------------------------------------------------------
// Sine and cosine evaluator
// Pipelined fixed-point sine and cosine: range reduction, five Horner steps
// over both polynomials in parallel, then rounding and clamping.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial #(
  parameter int ANGLE_FRAC_BITS  = 16,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sine_o,
  output logic signed [31:0] cosine_o
);
  import sincos_pkg::*;

  // Requests between the sections.
  logic step_valid [HORNER_STEPS+1];
  logic step_ready [HORNER_STEPS+1];
  arg_t step_arg   [HORNER_STEPS+1];
  acc_t step_sacc  [HORNER_STEPS+1];
  acc_t step_cacc  [HORNER_STEPS+1];

  // Range reduction and squaring.
  sincos_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .angle_i    (angle_i),
    .out_valid_o(step_valid[0]),
    .out_ready_i(step_ready[0]),
    .arg_o      (step_arg[0])
  );

  assign step_sacc[0] = SIN_INIT;
  assign step_cacc[0] = COS_INIT;

  // Horner steps, one per coefficient.
  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
    sincos_horner u_horner (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (step_valid[k]),
      .in_ready_o (step_ready[k]),
      .arg_i      (step_arg[k]),
      .sin_acc_i  (step_sacc[k]),
      .cos_acc_i  (step_cacc[k]),
      .sin_add_i  (SIN_ADD[k]),
      .cos_add_i  (COS_ADD[k]),
      .out_valid_o(step_valid[k+1]),
      .out_ready_i(step_ready[k+1]),
      .arg_o      (step_arg[k+1]),
      .sin_acc_o  (step_sacc[k+1]),
      .cos_acc_o  (step_cacc[k+1])
    );
  end

  // Final multiply, rounding and clamp.
  sincos_finish #(
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (step_valid[HORNER_STEPS]),
    .in_ready_o (step_ready[HORNER_STEPS]),
    .arg_i      (step_arg[HORNER_STEPS]),
    .sin_acc_i  (step_sacc[HORNER_STEPS]),
    .cos_acc_i  (step_cacc[HORNER_STEPS]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sine_o     (sine_o),
    .cosine_o   (cosine_o)
  );

endmodule

[sv/sincos_reduce.sv]
// ----------------------------------------------------------------------------
// Angle range reduction
// Reduces the angle modulo 2*pi, folds it into [-pi/2, pi/2], rounds it to
// Q.30 and squares it, over eight elastic pipeline stages.
// ----------------------------------------------------------------------------
module sincos_reduce #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sincos_pkg::arg_t   arg_o
);
  import sincos_pkg::*;

  localparam int NS   = REDUCE_STAGES;
  localparam int PW   = 60;                    // |angle| * 1/(2*pi) product
  localparam int QSH  = ANGLE_FRAC_BITS + 30;  // quotient rounding shift
  localparam int QMW  = PW - QSH;              // quotient magnitude width
  localparam int QPW  = QMW + 35;              // quotient * 2*pi width
  localparam int AWW  = 64 - ANGLE_FRAC_BITS;  // angle in Q.32
  localparam int YFW  = QPW + 2;               // full-width difference
  localparam int YW   = 37;                    // reduced angle, Q.32

  localparam logic [27:0] INV_TWO_PI_Q30   = 28'd170891319;
  localparam logic [34:0] TWO_PI_Q32       = 35'd26986075409;
  localparam logic signed [YW-1:0] PI_Q32      = 37'sd13493037705;
  localparam logic signed [YW-1:0] HALF_PI_Q32 = 37'sd6746518852;

  // Elastic valid chain: a stage loads when it is empty or its successor
  // takes its content.
  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] ld;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign vin        = {vld_q[NS-2:0], in_valid_i};
  assign ld         = vin & rdy[NS-1:0];
  assign in_ready_o = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~rdy[NS-1:0]) | (vin & rdy[NS-1:0]);
    end
  end

  // Stage 0: magnitude of the angle times 1/(2*pi).
  logic [31:0]        amag;
  logic [PW-1:0]      s0_prod_q;
  logic               s0_neg_q;
  logic signed [31:0] s0_ang_q;

  assign amag = angle_i[31] ? 32'(-angle_i) : 32'(angle_i);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s0_prod_q <= PW'(amag) * PW'(INV_TWO_PI_Q30);
      s0_neg_q  <= angle_i[31];
      s0_ang_q  <= angle_i;
    end
  end

  // Stage 1: round the quotient half away from zero to an integer.
  logic [PW-1:0]      qsum;
  logic [QMW-1:0]     s1_qmag_q;
  logic               s1_qneg_q;
  logic signed [31:0] s1_ang_q;

  assign qsum = s0_prod_q + (PW'(1) << (QSH - 1));

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s1_qmag_q <= qsum[QSH +: QMW];
      s1_qneg_q <= s0_neg_q;
      s1_ang_q  <= s0_ang_q;
    end
  end

  // Stage 2: quotient times 2*pi.
  logic [QPW-1:0]     s2_qp_q;
  logic               s2_qneg_q;
  logic signed [31:0] s2_ang_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      s2_qp_q   <= QPW'(s1_qmag_q) * QPW'(TWO_PI_Q32);
      s2_qneg_q <= s1_qneg_q;
      s2_ang_q  <= s1_ang_q;
    end
  end

  // Stage 3: subtract the whole turns from the widened angle.
  logic signed [AWW-1:0] a_wide;
  logic signed [YFW-1:0] a_ext;
  logic signed [YFW-1:0] qp_pos;
  logic signed [YFW-1:0] qp_s;
  logic signed [YFW-1:0] y_full;
  logic signed [YW-1:0]  s3_y_q;

  assign a_wide = $signed({s2_ang_q, {(32 - ANGLE_FRAC_BITS){1'b0}}});
  assign a_ext  = {{(YFW - AWW){a_wide[AWW-1]}}, a_wide};
  assign qp_pos = $signed({2'b00, s2_qp_q});
  assign qp_s   = s2_qneg_q ? -qp_pos : qp_pos;
  assign y_full = a_ext - qp_s;

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      s3_y_q <= y_full[YW-1:0];
    end
  end

  // Stage 4: fold angles beyond a quarter turn towards zero.
  logic signed [YW-1:0] y_fold;
  logic                 flip;
  logic signed [YW-1:0] s4_y_q;
  logic                 s4_flip_q;

  always_comb begin
    y_fold = s3_y_q;
    flip   = 1'b0;
    if (s3_y_q > HALF_PI_Q32) begin
      y_fold = PI_Q32 - s3_y_q;
      flip   = 1'b1;
    end else if (s3_y_q < -HALF_PI_Q32) begin
      y_fold = -PI_Q32 - s3_y_q;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      s4_y_q    <= y_fold;
      s4_flip_q <= flip;
    end
  end

  // Stage 5: round the folded angle half away from zero to Q.30.
  logic [YW-1:0] ymag;
  logic [YW-1:0] ysum;
  logic          s5_neg_q;
  logic [30:0]   s5_mag_q;
  logic          s5_flip_q;

  assign ymag = s4_y_q[YW-1] ? YW'(-s4_y_q) : YW'(s4_y_q);
  assign ysum = ymag + YW'(2);

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      s5_neg_q  <= s4_y_q[YW-1];
      s5_mag_q  <= ysum[32:2];
      s5_flip_q <= s4_flip_q;
    end
  end

  // Stage 6: square the reduced angle.
  logic [61:0] s6_sq_q;
  logic        s6_neg_q;
  logic [30:0] s6_mag_q;
  logic        s6_flip_q;

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      s6_sq_q   <= 62'(s5_mag_q) * 62'(s5_mag_q);
      s6_neg_q  <= s5_neg_q;
      s6_mag_q  <= s5_mag_q;
      s6_flip_q <= s5_flip_q;
    end
  end

  // Stage 7: round the square back to Q.30.
  logic [61:0] sqsum;
  arg_t        s7_arg_q;

  assign sqsum = s6_sq_q + (62'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      s7_arg_q.y2      <= sqsum[61:30];
      s7_arg_q.y30_neg <= s6_neg_q;
      s7_arg_q.y30_mag <= s6_mag_q;
      s7_arg_q.flip    <= s6_flip_q;
    end
  end

  assign arg_o = s7_arg_q;

endmodule

[sv/sincos_horner.sv]
// ----------------------------------------------------------------------------
// Horner step
// One Horner step for both polynomials: each accumulator is multiplied by
// y*y, rounded back to Q.30 and has its next coefficient added.
// ----------------------------------------------------------------------------
module sincos_horner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sincos_pkg::arg_t   arg_i,
  input  sincos_pkg::acc_t   sin_acc_i,
  input  sincos_pkg::acc_t   cos_acc_i,
  input  sincos_pkg::acc_t   sin_add_i,
  input  sincos_pkg::acc_t   cos_add_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sincos_pkg::arg_t   arg_o,
  output sincos_pkg::acc_t   sin_acc_o,
  output sincos_pkg::acc_t   cos_acc_o
);
  import sincos_pkg::*;

  localparam int NS = 2;

  // Elastic valid chain.
  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] ld;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign vin         = {vld_q[NS-2:0], in_valid_i};
  assign ld          = vin & rdy[NS-1:0];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~rdy[NS-1:0]) | (vin & rdy[NS-1:0]);
    end
  end

  // Stage A: multiply the accumulator magnitudes by y*y.
  logic [31:0] smag;
  logic [31:0] cmag;
  logic [63:0] a_sprod_q;
  logic [63:0] a_cprod_q;
  logic        a_sneg_q;
  logic        a_cneg_q;
  arg_t        a_arg_q;

  assign smag = sin_acc_i[31] ? 32'(-sin_acc_i) : 32'(sin_acc_i);
  assign cmag = cos_acc_i[31] ? 32'(-cos_acc_i) : 32'(cos_acc_i);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      a_sprod_q <= 64'(smag) * 64'(arg_i.y2);
      a_cprod_q <= 64'(cmag) * 64'(arg_i.y2);
      a_sneg_q  <= sin_acc_i[31];
      a_cneg_q  <= cos_acc_i[31];
      a_arg_q   <= arg_i;
    end
  end

  // Stage B: round half away from zero, restore the sign, add the coefficient.
  logic [63:0]        ssum;
  logic [63:0]        csum;
  logic signed [34:0] spos;
  logic signed [34:0] cpos;
  logic signed [34:0] sval;
  logic signed [34:0] cval;
  logic signed [34:0] snext;
  logic signed [34:0] cnext;
  acc_t               b_sacc_q;
  acc_t               b_cacc_q;
  arg_t               b_arg_q;

  assign ssum  = a_sprod_q + (64'd1 << 29);
  assign csum  = a_cprod_q + (64'd1 << 29);
  assign spos  = $signed({1'b0, ssum[63:30]});
  assign cpos  = $signed({1'b0, csum[63:30]});
  assign sval  = a_sneg_q ? -spos : spos;
  assign cval  = a_cneg_q ? -cpos : cpos;
  assign snext = sval + 35'(sin_add_i);
  assign cnext = cval + 35'(cos_add_i);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      b_sacc_q <= snext[31:0];
      b_cacc_q <= cnext[31:0];
      b_arg_q  <= a_arg_q;
    end
  end

  assign sin_acc_o = b_sacc_q;
  assign cos_acc_o = b_cacc_q;
  assign arg_o     = b_arg_q;

endmodule

[sv/sincos_finish.sv]
// ----------------------------------------------------------------------------
// Result finishing
// Multiplies the sine polynomial by the angle, applies the cosine sign,
// rounds both to the result format and clamps them to plus or minus one.
// ----------------------------------------------------------------------------
module sincos_finish #(
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sincos_pkg::arg_t   arg_i,
  input  sincos_pkg::acc_t   sin_acc_i,
  input  sincos_pkg::acc_t   cos_acc_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sine_o,
  output logic signed [31:0] cosine_o
);
  import sincos_pkg::*;

  localparam int NS = FINISH_STAGES;
  localparam int VW = 34;
  localparam int SH = 30 - RESULT_FRAC_BITS;
  localparam logic [VW-1:0] HALF_LSB = VW'((64'd1 << SH) >> 1);
  localparam logic [VW-1:0] LIM      = VW'(64'd1 << RESULT_FRAC_BITS);

  // Round half away from zero to the result format, then clamp.
  function automatic logic signed [31:0] finish_val(input logic signed [VW-1:0] v);
    logic [VW-1:0] mag;
    logic [VW-1:0] rmag;
    logic [31:0]   res;
    mag  = v[VW-1] ? VW'(-v) : VW'(v);
    rmag = (mag + HALF_LSB) >> SH;
    if (rmag > LIM) begin
      rmag = LIM;
    end
    res = rmag[31:0];
    return v[VW-1] ? $signed(-res) : $signed(res);
  endfunction

  // Elastic valid chain.
  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] ld;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign vin         = {vld_q[NS-2:0], in_valid_i};
  assign ld          = vin & rdy[NS-1:0];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~rdy[NS-1:0]) | (vin & rdy[NS-1:0]);
    end
  end

  // Stage 0: sine polynomial times the reduced angle.
  logic [31:0] smag;
  logic [62:0] f0_sprod_q;
  logic        f0_sneg_q;
  acc_t        f0_cacc_q;
  logic        f0_flip_q;

  assign smag = sin_acc_i[31] ? 32'(-sin_acc_i) : 32'(sin_acc_i);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      f0_sprod_q <= 63'(smag) * 63'(arg_i.y30_mag);
      f0_sneg_q  <= sin_acc_i[31] ^ arg_i.y30_neg;
      f0_cacc_q  <= cos_acc_i;
      f0_flip_q  <= arg_i.flip;
    end
  end

  // Stage 1: round the sine product to Q.30 and negate the cosine on a fold.
  logic [62:0]          ssum;
  logic signed [VW-1:0] spos;
  logic signed [VW-1:0] cext;
  logic signed [VW-1:0] f1_sine_q;
  logic signed [VW-1:0] f1_cosine_q;

  assign ssum = f0_sprod_q + (63'd1 << 29);
  assign spos = $signed({1'b0, ssum[62:30]});
  assign cext = VW'(f0_cacc_q);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      f1_sine_q   <= f0_sneg_q ? -spos : spos;
      f1_cosine_q <= f0_flip_q ? -cext : cext;
    end
  end

  // Stage 2: output register with the final rounding and clamp.
  logic signed [31:0] f2_sine_q;
  logic signed [31:0] f2_cosine_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      f2_sine_q   <= finish_val(f1_sine_q);
      f2_cosine_q <= finish_val(f1_cosine_q);
    end
  end

  assign sine_o   = f2_sine_q;
  assign cosine_o = f2_cosine_q;

endmodule

[sv/sincos_checker.sv]
// ----------------------------------------------------------------------------
// Sine and cosine port checker
// Watches the ports of the evaluator: results only for accepted requests,
// no more in flight than the pipeline holds, and results within range.
// ----------------------------------------------------------------------------
module sincos_checker #(
  parameter int RESULT_FRAC_BITS = 30
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] sine_i,
  input logic signed [31:0] cosine_i
);
  import sincos_pkg::*;

  localparam int CW = $clog2(SINCOS_LATENCY + 1);
  localparam logic [CW-1:0] MAX_PENDING = CW'(SINCOS_LATENCY);
  localparam logic signed [31:0] LIM = 32'(64'd1 << RESULT_FRAC_BITS);

  logic          in_acc;
  logic          out_acc;
  logic [CW-1:0] pending_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Requests accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + CW'(in_acc) - CW'(out_acc);
    end
  end

  // The valid bits are only known to be clear once a reset edge has been seen.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid after a reset cycle");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result shown without an outstanding request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= MAX_PENDING)
    else $error("more requests in flight than pipeline stages");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sine_i) && $stable(cosine_i))
    else $error("stalled result changed or dropped");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sine_i <= LIM && sine_i >= -LIM && cosine_i <= LIM && cosine_i >= -LIM)
    else $error("result beyond plus or minus one");

endmodule

bind sine_cosine_polynomial sincos_checker #(
  .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
) u_sincos_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .sine_i     (sine_o),
  .cosine_i   (cosine_o)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine and cosine evaluator testbench
// Sends angles through the valid/ready request channel and predicts each
// sine and cosine pair in fixed point. Every result is compared with the
// oldest outstanding prediction, with random idling on both sides, a long
// hold-off at the output and a final stretch at full rate.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ANGLE_FRAC_BITS  = 16;
  localparam int RESULT_FRAC_BITS = 30;

  // Cycles without any accepted request before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the long output hold-off.
  localparam int HOLD_CYCLES    = 200;
  // Cycles allowed to pass once nothing is outstanding.
  localparam int DRAIN_CYCLES   = 40;

  // Range reduction constants: 1/(2*pi) in Q.30, 2*pi, pi and pi/2 in Q.32.
  localparam longint TURN_RECIP_Q30   = 64'sd170891319;
  localparam longint TURN_Q32         = 64'sd26986075409;
  localparam longint HALF_TURN_Q32    = 64'sd13493037705;
  localparam longint QUARTER_TURN_Q32 = 64'sd6746518852;

  // Polynomial coefficients in Q.30, highest order first.
  localparam longint SIN_K5 = 64'sd26;
  localparam longint SIN_K4 = 64'sd2956;
  localparam longint SIN_K3 = 64'sd213040;
  localparam longint SIN_K2 = 64'sd8947846;
  localparam longint SIN_K1 = 64'sd178956974;
  localparam longint COS_K5 = 64'sd280;
  localparam longint COS_K4 = 64'sd26586;
  localparam longint COS_K3 = 64'sd1491253;
  localparam longint COS_K2 = 64'sd44739212;
  localparam longint COS_K1 = 64'sd536870912;
  localparam longint UNITY_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } trig_pair_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] angle_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] sine_o;
  logic signed [31:0] cosine_o;

  trig_pair_t pending_trig [$];
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;
  bit         sender_idles   = 1'b1;
  bit         receiver_stalls = 1'b1;
  bit         hold_off_req   = 1'b0;

  sine_cosine_polynomial #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .angle_i    (angle_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sine_o     (sine_o),
    .cosine_o   (cosine_o)
  );

  // Clock generation.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Arithmetic shift right by s bits, rounding half away from zero.
  function automatic longint round_away(input longint v, input int s);
    logic [63:0] m;
    if (s == 0) return v;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -$signed(m) : $signed(m);
  endfunction

  // Product of two Q.30 values, rounded half away from zero back to Q.30.
  function automatic longint mul_q30(input longint a, input longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m  = ma * mb;
    m  = (m + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
  endfunction

  // Rounds a Q.30 value to the result format and clamps it to plus or minus one.
  function automatic logic signed [31:0] clamp_to_unit(input longint v);
    longint r;
    longint lim;
    lim = 64'sd1 <<< RESULT_FRAC_BITS;
    r   = round_away(v, 30 - RESULT_FRAC_BITS);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[31:0];
  endfunction

  // Sine and cosine of one angle, as the block is to produce them.
  function automatic trig_pair_t sincos_of_angle(input logic signed [31:0] angle);
    longint     ang;
    longint     turns;
    longint     y;
    longint     y30;
    longint     y2;
    longint     s;
    longint     c;
    logic       flip;
    trig_pair_t r;
    ang   = angle;
    turns = round_away(ang * TURN_RECIP_Q30, ANGLE_FRAC_BITS + 30);
    y     = (ang <<< (32 - ANGLE_FRAC_BITS)) - turns * TURN_Q32;
    flip  = 1'b0;
    // Fold the outer quadrants back into [-pi/2, pi/2]; exactly pi/2 stays.
    if (y > QUARTER_TURN_Q32) begin
      y    = HALF_TURN_Q32 - y;
      flip = 1'b1;
    end else if (y < -QUARTER_TURN_Q32) begin
      y    = -HALF_TURN_Q32 - y;
      flip = 1'b1;
    end
    y30 = round_away(y, 2);
    y2  = mul_q30(y30, y30);

    // Horner evaluation of both polynomials in y squared.
    s = mul_q30(-SIN_K5, y2) + SIN_K4;
    s = mul_q30(s, y2) - SIN_K3;
    s = mul_q30(s, y2) + SIN_K2;
    s = mul_q30(s, y2) - SIN_K1;
    s = mul_q30(s, y2) + UNITY_Q30;
    s = mul_q30(s, y30);

    c = mul_q30(-COS_K5, y2) + COS_K4;
    c = mul_q30(c, y2) - COS_K3;
    c = mul_q30(c, y2) + COS_K2;
    c = mul_q30(c, y2) - COS_K1;
    c = mul_q30(c, y2) + UNITY_Q30;
    if (flip) c = -c;

    r.sine   = clamp_to_unit(s);
    r.cosine = clamp_to_unit(c);
    return r;
  endfunction

  // Random angle: full range, within about one turn, near quadrant edges, or mid range.
  function automatic logic signed [31:0] random_angle();
    int k;
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: begin
        v = $urandom_range(0, 917504);
        v = v - 458752;
      end
      2: begin
        k = $urandom_range(0, 80);
        v = $urandom_range(0, 16);
        v = (k - 40) * 102944 + v - 8;
      end
      default: begin
        v = $urandom_range(0, 32'h01FF_FFFF);
        v = v - 32'h0100_0000;
      end
    endcase
    return v;
  endfunction

  // Offers one angle, after an optional idle burst, and waits for acceptance.
  task automatic send_angle(input logic signed [31:0] angle);
    int gap;
    gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    angle_i    <= angle;
    do @(posedge clk_i); while (!in_ready_o);
    pending_trig.push_back(sincos_of_angle(angle));
  endtask

  // Corners of the angle range, quadrant edges and rounding boundaries.
  task automatic test_directed_angles();
    send_angle(32'sd0);
    send_angle(32'sd1);
    send_angle(-32'sd1);
    send_angle(32'sh7FFF_FFFF);
    send_angle(32'sh8000_0000);
    send_angle(32'sh0000_7FFF);
    send_angle(32'sd65536);
    send_angle(32'sd51472);
    // Either side of plus and minus pi/2.
    send_angle(32'sd102943);
    send_angle(32'sd102944);
    send_angle(-32'sd102943);
    send_angle(-32'sd102944);
    send_angle(32'sd154416);
    send_angle(-32'sd154416);
    // Around pi, where the turn count rounds, at one turn and at three half turns.
    send_angle(32'sd205887);
    send_angle(32'sd205888);
    send_angle(-32'sd205887);
    send_angle(32'sd411775);
    send_angle(32'sd617662);
    send_angle(-32'sd617662);
    send_angle(32'sh5555_5555);
    send_angle(32'shAAAA_AAAA);
  endtask

  // Random angles with idling on both sides.
  task automatic test_random_angles();
    repeat (350) send_angle(random_angle());
  endtask

  // The output holds off for a long stretch while angles keep coming.
  task automatic test_backpressure();
    sender_idles = 1'b0;
    hold_off_req = 1'b1;
    repeat (60) send_angle(random_angle());
    while (hold_off_req) @(posedge clk_i);
    sender_idles = 1'b1;
  endtask

  // Full rate with no idling on either side.
  task automatic test_steady_stream();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    repeat (90) send_angle(random_angle());
  endtask

  // Output ready: random stall bursts, and the long hold-off when requested.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Result checking against the oldest outstanding prediction.
  always @(posedge clk_i) begin : check_result
    trig_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_trig.size() == 0) begin
        $error("unexpected result: sine %0d, cosine %0d", sine_o, cosine_o);
        mismatch_count++;
      end else begin
        want = pending_trig.pop_front();
        if (sine_o !== want.sine) begin
          $error("sine: expected %0d, actual %0d", want.sine, sine_o);
          mismatch_count++;
        end
        if (cosine_o !== want.cosine) begin
          $error("cosine: expected %0d, actual %0d", want.cosine, cosine_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no request is accepted on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_angles();
    test_random_angles();
    test_backpressure();
    test_steady_stream();
    in_valid_i <= 1'b0;
    while (pending_trig.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
